@@ src/ats_pkg.sv @@
// package for the alert tone sequencer: request and result types, codes,
// and tone timing constants derived from the sample rate
`timescale 1ns / 1ps
`default_nettype none

package ats_pkg;

  localparam int SAMPLE_RATE_HZ = 50000;

  // action codes
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_PLAY = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  // sound codes
  localparam logic [1:0] SND_SUCCESS = 2'd0;
  localparam logic [1:0] SND_FAILURE = 2'd1;
  localparam logic [1:0] SND_SIREN   = 2'd2;

  // register indexes
  localparam int            REG_IDX_W      = 2;
  localparam logic [REG_IDX_W-1:0] REG_LOW_LEVEL  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_LEVEL = 2'd1;

  localparam logic [7:0] LOW_LEVEL_RESET  = 8'd30;
  localparam logic [7:0] HIGH_LEVEL_RESET = 8'd150;

  // half periods, never below one sample
  localparam int HALF_440_RAW = SAMPLE_RATE_HZ / (2 * 440);
  localparam int HALF_220_RAW = SAMPLE_RATE_HZ / (2 * 220);
  localparam int HALF_110_RAW = SAMPLE_RATE_HZ / (2 * 110);
  localparam int HALF_440_I   = (HALF_440_RAW == 0) ? 1 : HALF_440_RAW;
  localparam int HALF_220_I   = (HALF_220_RAW == 0) ? 1 : HALF_220_RAW;
  localparam int HALF_110_I   = (HALF_110_RAW == 0) ? 1 : HALF_110_RAW;

  // sound lengths in samples
  localparam int LEN_SUCCESS_I = SAMPLE_RATE_HZ / 2;
  localparam int LEN_FAILURE_I = 3 * SAMPLE_RATE_HZ / 2;
  localparam int LEN_SIREN_I   = SAMPLE_RATE_HZ;
  localparam int THIRD_I       = LEN_FAILURE_I / 3;
  localparam int SPLIT_I       = SAMPLE_RATE_HZ / 2;

  // phase of the 220 Hz tone where the siren changes pitch
  localparam int SPLIT_Q_I = SPLIT_I / HALF_220_I;
  localparam int SPLIT_R_I = SPLIT_I % HALF_220_I;

  localparam int IDX_W  = $clog2(LEN_FAILURE_I + 1);
  localparam int HALF_W = $clog2(HALF_110_I + 1);

  localparam logic [IDX_W-1:0]  LEN_SUCCESS = IDX_W'(LEN_SUCCESS_I);
  localparam logic [IDX_W-1:0]  LEN_FAILURE = IDX_W'(LEN_FAILURE_I);
  localparam logic [IDX_W-1:0]  LEN_SIREN   = IDX_W'(LEN_SIREN_I);
  localparam logic [IDX_W-1:0]  THIRD       = IDX_W'(THIRD_I);
  localparam logic [IDX_W-1:0]  TWO_THIRDS  = IDX_W'(2 * THIRD_I);
  localparam logic [IDX_W-1:0]  SPLIT       = IDX_W'(SPLIT_I);
  localparam logic [HALF_W-1:0] HALF_440    = HALF_W'(HALF_440_I);
  localparam logic [HALF_W-1:0] HALF_220    = HALF_W'(HALF_220_I);
  localparam logic [HALF_W-1:0] HALF_110    = HALF_W'(HALF_110_I);
  localparam logic [HALF_W-1:0] SPLIT_CNT   = HALF_W'(SPLIT_R_I);
  localparam logic              SPLIT_PHASE = ((SPLIT_Q_I % 2) == 1);

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] sound;
  } ats_in_t;

  typedef struct packed {
    logic [7:0] level;
    logic       playing;
  } ats_out_t;

endpackage

`default_nettype wire

@@ src/ats_tone.sv @@
// tone state and sample generation for the alert tone sequencer
// depends on ats_pkg
`timescale 1ns / 1ps
`default_nettype none

module ats_tone (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire ats_pkg::ats_in_t req,
  input  wire logic [7:0]       low_level,
  input  wire logic [7:0]       high_level,
  output ats_pkg::ats_out_t     result
);
  import ats_pkg::*;

  logic [IDX_W-1:0]  sample_index, sample_index_next;
  logic [HALF_W-1:0] half_cnt, half_cnt_next;
  logic              phase, phase_next;
  logic [1:0]        current_sound, current_sound_next;
  logic              busy, busy_next;
  logic [7:0]        held_level, held_level_next;

  logic [HALF_W-1:0] half;
  logic [IDX_W-1:0]  len;
  logic [7:0]        amp;
  logic              silent;
  logic [7:0]        sample;
  logic [IDX_W-1:0]  idx_inc;
  logic [HALF_W:0]   cnt_inc;

  always_comb begin
    case (current_sound)
      SND_SUCCESS: begin
        half = HALF_440;
        len  = LEN_SUCCESS;
        amp  = low_level;
      end
      SND_FAILURE: begin
        half = HALF_220;
        len  = LEN_FAILURE;
        amp  = low_level;
      end
      default: begin
        half = (sample_index < SPLIT) ? HALF_110 : HALF_220;
        len  = LEN_SIREN;
        amp  = high_level;
      end
    endcase
    // middle third of the failure chime is silent
    silent  = (current_sound == SND_FAILURE) && (sample_index >= THIRD) &&
              (sample_index < TWO_THIRDS);
    sample  = (phase && !silent) ? amp : 8'd0;
    idx_inc = sample_index + IDX_W'(1);
    cnt_inc = {1'b0, half_cnt} + (HALF_W + 1)'(1);
  end

  always_comb begin
    sample_index_next  = sample_index;
    half_cnt_next      = half_cnt;
    phase_next         = phase;
    current_sound_next = current_sound;
    busy_next          = busy;
    held_level_next    = held_level;
    if (take) begin
      case (req.action)
        ACT_TICK: begin
          if (busy) begin
            held_level_next = sample;
            if (idx_inc >= len) begin
              sample_index_next = '0;
              half_cnt_next     = '0;
              phase_next        = 1'b0;
              busy_next         = (current_sound == SND_SIREN);
            end else begin
              sample_index_next = idx_inc;
              if ((current_sound == SND_SIREN) && (idx_inc == SPLIT)) begin
                // siren rises from 110 Hz to 220 Hz mid-way through its length
                half_cnt_next = SPLIT_CNT;
                phase_next    = SPLIT_PHASE;
              end else if (cnt_inc == {1'b0, half}) begin
                half_cnt_next = '0;
                phase_next    = !phase;
              end else begin
                half_cnt_next = cnt_inc[HALF_W-1:0];
              end
            end
          end
        end
        ACT_PLAY: begin
          if (!busy && (req.sound <= SND_SIREN)) begin
            sample_index_next  = '0;
            half_cnt_next      = '0;
            phase_next         = 1'b0;
            current_sound_next = req.sound;
            busy_next          = 1'b1;
          end
        end
        ACT_STOP: begin
          busy_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.level   = held_level_next;
    result.playing = busy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index  <= '0;
      half_cnt      <= '0;
      phase         <= 1'b0;
      current_sound <= SND_SUCCESS;
      busy          <= 1'b0;
      held_level    <= 8'd0;
    end else begin
      sample_index  <= sample_index_next;
      half_cnt      <= half_cnt_next;
      phase         <= phase_next;
      current_sound <= current_sound_next;
      busy          <= busy_next;
      held_level    <= held_level_next;
    end
  end

endmodule

`default_nettype wire

@@ src/alert_tone_sequencer_unit.sv @@
// alert tone sequencer: one result per request, one request per cycle while the
// skid register is empty. a taken request's result goes to the output register,
// or to the skid register while the output holds a waiting result; stall on the
// output thus reaches the input only once the skid register is full.
// reset: tone state cleared, levels back to 30 and 150, output empty.
`timescale 1ns / 1ps
`default_nettype none

module alert_tone_sequencer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire ats_pkg::ats_in_t                in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output ats_pkg::ats_out_t                    out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ats_pkg::REG_IDX_W-1:0]   cfg_index,
  input  wire logic [7:0]                      cfg_data
);
  import ats_pkg::*;

  logic [7:0] low_level;
  logic [7:0] high_level;
  logic       take;
  logic       pop;
  ats_out_t   result;
  ats_out_t   skid_data;
  logic       skid_valid;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign take      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_level  <= LOW_LEVEL_RESET;
      high_level <= HIGH_LEVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_LEVEL:  low_level  <= cfg_data;
        REG_HIGH_LEVEL: high_level <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ats_tone u_tone (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .req        (in_data),
    .low_level  (low_level),
    .high_level (high_level),
    .result     (result)
  );

  // output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (take) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (take) begin
      if (!out_valid || pop) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end
  end

endmodule

`default_nettype wire

@@ dv/alert_tone_sequencer_unit_test.sv @@
// self-checking bench for alert_tone_sequencer_unit: queued requests, a tone
// predictor and a result checker, with random idling on both sides
// depends on src/ats_pkg.sv and src/alert_tone_sequencer_unit.sv
`timescale 1ns / 1ps

module alert_tone_sequencer_unit_test;
  import ats_pkg::*;

  // codes with no meaning to the block
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [1:0] SND_NONE = 2'd3;
  localparam logic [7:0] LEVEL_MAX = 8'd249;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ats_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ats_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  alert_tone_sequencer_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  ats_in_t pending_requests[$];
  ats_out_t expected_results[$];
  int mismatches = 0;
  logic calm = 1'b0;

  // predictor state
  int unsigned tone_idx = 0;
  logic [1:0] tone_sound = SND_SUCCESS;
  logic tone_busy = 1'b0;
  logic [7:0] tone_level = 8'd0;
  logic [7:0] chime_level = 8'd30;
  logic [7:0] siren_level = 8'd150;

  function automatic logic [7:0] square(int unsigned idx, int unsigned freq, logic [7:0] amp);
    int unsigned half;
    half = SAMPLE_RATE_HZ / (2 * freq);
    if (half == 0) half = 1;
    return ((idx / half) % 2 == 1) ? amp : 8'd0;
  endfunction

  function automatic int unsigned sound_length(logic [1:0] snd);
    if (snd == SND_SUCCESS) return SAMPLE_RATE_HZ / 2;
    if (snd == SND_FAILURE) return 3 * SAMPLE_RATE_HZ / 2;
    return SAMPLE_RATE_HZ;
  endfunction

  function automatic logic [7:0] tone_sample(logic [1:0] snd, int unsigned idx);
    int unsigned third;
    third = sound_length(SND_FAILURE) / 3;
    if (snd == SND_SUCCESS) return square(idx, 440, chime_level);
    if (snd == SND_FAILURE) begin
      // middle third of the failure chime is silent
      if (idx < third) return square(idx, 220, chime_level);
      if (idx < 2 * third) return 8'd0;
      return square(idx, 220, chime_level);
    end
    if (idx < SAMPLE_RATE_HZ / 2) return square(idx, 110, siren_level);
    return square(idx, 220, siren_level);
  endfunction

  function automatic ats_out_t predict_tone(ats_in_t req);
    ats_out_t res;
    case (req.action)
      ACT_TICK: begin
        if (tone_busy) begin
          tone_level = tone_sample(tone_sound, tone_idx);
          tone_idx++;
          if (tone_idx >= sound_length(tone_sound)) begin
            tone_idx = 0;
            if (tone_sound != SND_SIREN) tone_busy = 1'b0;
          end
        end
      end
      ACT_PLAY: begin
        if (!tone_busy && req.sound <= SND_SIREN) begin
          tone_idx = 0;
          tone_sound = req.sound;
          tone_busy = 1'b1;
        end
      end
      ACT_STOP: tone_busy = 1'b0;
      default: ;
    endcase
    res.level = tone_level;
    res.playing = tone_busy;
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(predict_tone(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
          in_data <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    ats_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result level %0d playing %0b",
                                  out_data.level, out_data.playing));
        end else begin
          want = expected_results.pop_front();
          if (out_data.level !== want.level)
            note_mismatch($sformatf("level: expected %0d, got %0d", want.level, out_data.level));
          if (out_data.playing !== want.playing)
            note_mismatch($sformatf("playing: expected %0b, got %0b",
                                    want.playing, out_data.playing));
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 33);
    end
  end

  task automatic send(input logic [1:0] action, input logic [1:0] sound);
    ats_in_t req;
    req.action = action;
    req.sound = sound;
    pending_requests.push_back(req);
  endtask

  task automatic tick_run(input int n);
    repeat (n) send(ACT_TICK, 2'($urandom_range(3)));
  endtask

  // wait until every request is taken and every result has come back
  task automatic drain();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_LOW_LEVEL) chime_level = val;
    else if (idx == REG_HIGH_LEVEL) siren_level = val;
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return LEVEL_MAX;
      default: return 8'($urandom_range(LEVEL_MAX));
    endcase
  endfunction

  initial begin : stimulus
    int shaped;
    int run;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset levels, idle behaviour and ignored requests
    send(ACT_TICK, SND_SUCCESS);
    send(ACT_NONE, SND_NONE);
    send(ACT_STOP, SND_FAILURE);
    send(ACT_PLAY, SND_NONE);
    send(ACT_PLAY, SND_SUCCESS);
    send(ACT_PLAY, SND_SIREN);
    tick_run(4);
    send(ACT_STOP, SND_SUCCESS);
    send(ACT_TICK, SND_SIREN);
    send(ACT_PLAY, SND_FAILURE);
    tick_run(2);
    send(ACT_NONE, SND_SUCCESS);
    send(ACT_STOP, SND_NONE);
    send(ACT_PLAY, SND_SIREN);
    tick_run(2);
    send(ACT_STOP, SND_SIREN);
    drain();

    // longer stretches of each sound, success and siren at the extreme levels
    write_reg(REG_LOW_LEVEL, LEVEL_MAX);
    write_reg(REG_HIGH_LEVEL, 8'd0);
    send(ACT_PLAY, SND_SUCCESS);
    tick_run(60);
    send(ACT_STOP, SND_SUCCESS);
    drain();
    write_reg(REG_LOW_LEVEL, pick_level());
    write_reg(REG_HIGH_LEVEL, LEVEL_MAX);
    send(ACT_PLAY, SND_FAILURE);
    tick_run(60);
    send(ACT_STOP, SND_FAILURE);
    drain();
    calm = 1'b1;
    send(ACT_PLAY, SND_SIREN);
    tick_run(120);
    send(ACT_STOP, SND_SIREN);
    drain();
    calm = 1'b0;

    // short play sequences with a little noise, levels changed between blocks
    repeat (4) begin
      write_reg(REG_LOW_LEVEL, pick_level());
      write_reg(REG_HIGH_LEVEL, pick_level());
      shaped = 0;
      while (shaped < 170) begin
        if ($urandom_range(99) < 75) begin
          send(ACT_PLAY, 2'($urandom_range(SND_SIREN)));
          shaped++;
          run = $urandom_range(1, 80);
          repeat (run) begin
            if ($urandom_range(99) < 5) begin
              send(2'($urandom_range(3)), 2'($urandom_range(3)));
            end else begin
              send(ACT_TICK, 2'($urandom_range(3)));
              shaped++;
            end
          end
          if ($urandom_range(1) == 1) begin
            send(ACT_STOP, 2'($urandom_range(3)));
            shaped++;
          end
        end else begin
          send(2'($urandom_range(3)), 2'($urandom_range(3)));
        end
        if ($urandom_range(99) < 4) drain();
      end
      drain();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("alert_tone_sequencer_unit test passed");
    end else begin
      $display("alert_tone_sequencer_unit test failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("alert_tone_sequencer_unit test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
src/ats_pkg.sv
src/ats_tone.sv
src/alert_tone_sequencer_unit.sv
dv/alert_tone_sequencer_unit_test.sv
